// ===== rtl/dssa_pkg.sv =====
// shared types and codes for the dual stack shared array block
package dssa_pkg;

   // request operation codes
   typedef enum logic [2:0] {
      OP_PUSH_A = 3'd0,
      OP_POP_A  = 3'd1,
      OP_LIST_A = 3'd2,
      OP_PUSH_B = 3'd3,
      OP_POP_B  = 3'd4,
      OP_LIST_B = 3'd5
   } opcode_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // decoded operation class
   typedef enum logic [1:0] {
      CLS_NONE = 2'd0,
      CLS_PUSH = 2'd1,
      CLS_POP  = 2'd2,
      CLS_LIST = 2'd3
   } op_class_type;

   // controller to datapath commands
   typedef struct packed {
      logic       capture;
      logic       push;
      logic       pop;
      logic       rd_en;
      logic       list_next;
      logic       load_data;
      logic       load_err;
      status_type err_status;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      op_class_type op_class;
      logic         full;
      logic         sel_empty;
      logic         last;
   } dp_stat_type;

endpackage

// ===== rtl/dssa_if.sv =====
// request and response channel interfaces for the dual stack shared array block

interface dssa_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         opcode;
   logic signed [31:0] push_value;

   modport source (output valid, output opcode, output push_value, input ready);
   modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface dssa_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] data_value;
   logic               last;

   modport source (output valid, output status, output data_value, output last, input ready);
   modport sink   (input valid, input status, input data_value, input last, output ready);
endinterface

// ===== rtl/dual_stack_shared_array_core.sv =====
// a taken request is decoded in S_DECODE; a push or error response is then sent from S_SEND,
// while a pop or list entry passes S_READ (registered store read) first; each further list
// entry returns through S_READ once the previous is taken; an unused opcode gets no response
// one request at a time: ready is back only after the final response; rsp_ready can stall it
// reset: synchronous, both stacks empty; store contents stay undefined, no clearing pass
// top level of the dual stack shared array block
module dual_stack_shared_array_core #(
   parameter int DEPTH = 8
) (
   input logic        clock,
   input logic        reset,
   dssa_req_if.sink   req_ch,
   dssa_rsp_if.source rsp_ch
);
   import dssa_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type st;

   // sequencer
   dssa_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .st        (st),
      .cmd       (cmd)
   );

   // counters, store and response registers
   dssa_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .st             (st),
      .req_opcode     (req_ch.opcode),
      .req_push_value (req_ch.push_value),
      .rsp_status     (rsp_ch.status),
      .rsp_data_value (rsp_ch.data_value),
      .rsp_last       (rsp_ch.last)
   );

endmodule

// ===== rtl/dssa_datapath.sv =====
// stack counters, entry memory and response registers
module dssa_datapath #(
   parameter int DEPTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dssa_pkg::dp_cmd_type cmd,
   output dssa_pkg::dp_stat_type st,
   input  logic [2:0]           req_opcode,
   input  logic signed [31:0]   req_push_value,
   output logic [1:0]           rsp_status,
   output logic signed [31:0]   rsp_data_value,
   output logic                 rsp_last
);
   import dssa_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   logic [CW-1:0]      count_a_ff, count_a_in;
   logic [CW-1:0]      count_b_ff, count_b_in;
   logic [CW-1:0]      idx_ff;
   logic [2:0]         op_ff;
   logic signed [31:0] value_ff;
   logic [31:0]        mem [DEPTH];
   logic [31:0]        rd_data_ff;
   logic [1:0]         status_ff;
   logic signed [31:0] data_ff;
   logic               last_ff;

   op_class_type  op_class;
   logic          sel_b;
   logic [CW-1:0] count_sel;
   logic [CW-1:0] k_rd;
   logic [CW-1:0] rd_addr;
   logic [CW-1:0] wr_addr;
   logic [CW:0]   fill;

   // decode the captured operation
   always_comb begin
      op_class = CLS_NONE;
      sel_b    = 1'b0;
      case (op_ff)
         OP_PUSH_A: op_class = CLS_PUSH;
         OP_POP_A:  op_class = CLS_POP;
         OP_LIST_A: op_class = CLS_LIST;
         OP_PUSH_B: begin
            op_class = CLS_PUSH;
            sel_b    = 1'b1;
         end
         OP_POP_B: begin
            op_class = CLS_POP;
            sel_b    = 1'b1;
         end
         OP_LIST_B: begin
            op_class = CLS_LIST;
            sel_b    = 1'b1;
         end
         default: begin
            op_class = CLS_NONE;
            sel_b    = 1'b0;
         end
      endcase
   end

   // address and occupancy arithmetic
   assign count_sel = sel_b ? count_b_ff : count_a_ff;
   assign k_rd      = cmd.list_next ? idx_ff + ONE_C : '0;
   assign rd_addr   = sel_b ? DEPTH_C - count_b_ff + k_rd : count_a_ff - ONE_C - k_rd;
   assign wr_addr   = sel_b ? DEPTH_C - ONE_C - count_b_ff : count_a_ff;
   assign fill      = {1'b0, count_a_ff} + {1'b0, count_b_ff};

   assign st.op_class  = op_class;
   assign st.full      = fill >= {1'b0, DEPTH_C};
   assign st.sel_empty = count_sel == '0;
   assign st.last      = last_ff;

   // next counter values
   always_comb begin
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      if (cmd.push) begin
         if (sel_b) count_b_in = count_b_ff + ONE_C;
         else       count_a_in = count_a_ff + ONE_C;
      end else if (cmd.pop) begin
         if (sel_b) count_b_in = count_b_ff - ONE_C;
         else       count_a_in = count_a_ff - ONE_C;
      end
   end

   // stack counters
   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff <= '0;
         count_b_ff <= '0;
      end else begin
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
      end
   end

   // captured request and list index
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_opcode;
         value_ff <= req_push_value;
      end
      if (cmd.rd_en) idx_ff <= k_rd;
   end

   // entry memory with registered read
   always_ff @(posedge clock) begin
      if (cmd.push) mem[wr_addr[AW-1:0]] <= value_ff;
      if (cmd.rd_en) rd_data_ff <= mem[rd_addr[AW-1:0]];
   end

   // response registers
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         status_ff <= ST_OK;
         data_ff   <= '0;
         last_ff   <= 1'b1;
      end else if (cmd.load_err) begin
         status_ff <= cmd.err_status;
         data_ff   <= '0;
         last_ff   <= 1'b1;
      end else if (cmd.load_data) begin
         status_ff <= ST_OK;
         data_ff   <= rd_data_ff;
         last_ff   <= (op_class == CLS_POP) || (idx_ff + ONE_C == count_sel);
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_data_value = data_ff;
   assign rsp_last       = last_ff;

endmodule

// ===== rtl/dssa_controller.sv =====
// request sequencer for the dual stack shared array block
module dssa_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  dssa_pkg::dp_stat_type st,
   output dssa_pkg::dp_cmd_type  cmd
);
   import dssa_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECODE,
      S_READ,
      S_SEND
   } state_type;

   state_type state_ff;
   logic      ready_ff;
   logic      valid_ff;
   logic      is_push;
   logic      is_read_op;
   logic      more_list;

   assign is_push    = st.op_class == CLS_PUSH;
   assign is_read_op = (st.op_class == CLS_POP) || (st.op_class == CLS_LIST);
   assign more_list  = (st.op_class == CLS_LIST) && !st.last;

   // datapath commands per state
   always_comb begin
      cmd = '0;
      cmd.err_status = ST_EMPTY;
      case (state_ff)
         S_IDLE: cmd.capture = ready_ff && req_valid;
         S_DECODE: begin
            cmd.push       = is_push && !st.full;
            cmd.load_err   = (is_push && st.full) || (is_read_op && st.sel_empty);
            cmd.err_status = is_push ? ST_FULL : ST_EMPTY;
            cmd.rd_en      = is_read_op && !st.sel_empty;
            cmd.pop        = (st.op_class == CLS_POP) && !st.sel_empty;
         end
         S_READ: cmd.load_data = 1'b1;
         S_SEND: begin
            cmd.rd_en     = rsp_ready && more_list;
            cmd.list_next = rsp_ready && more_list;
         end
         default: cmd = '0;
      endcase
   end

   // state and handshake registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (ready_ff && req_valid) begin
                  state_ff <= S_DECODE;
                  ready_ff <= 1'b0;
               end else begin
                  ready_ff <= 1'b1;
               end
            end
            S_DECODE: begin
               if (st.op_class == CLS_NONE) begin
                  state_ff <= S_IDLE;
               end else if (is_push || st.sel_empty) begin
                  state_ff <= S_SEND;
                  valid_ff <= 1'b1;
               end else begin
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_SEND;
               valid_ff <= 1'b1;
            end
            S_SEND: begin
               if (rsp_ready) begin
                  valid_ff <= 1'b0;
                  state_ff <= more_list ? S_READ : S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
               ready_ff <= 1'b0;
               valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_ready = ready_ff;
   assign rsp_valid = valid_ff;

endmodule

// ===== rtl/dssa_checker.sv =====
// port level checks for the dual stack shared array block, bound to the top level
module dssa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_data_value,
   input logic        rsp_last
);
   import dssa_pkg::*;

   // a stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_data_value) && $stable(rsp_last))
      else $error("response changed while stalled");

   // no new request taken while a response is pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while response pending");

   // a taken request closes the input until its work is done
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after request taken");

   // an error response ends its request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_last)
      else $error("error response not marked last");

   // an error response carries zero data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_data_value == '0)
      else $error("error response with nonzero data");

endmodule

bind dual_stack_shared_array_core dssa_checker u_dssa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_status     (rsp_ch.status),
   .rsp_data_value (rsp_ch.data_value),
   .rsp_last       (rsp_ch.last)
);
